// ----- design/buddy_block_allocator_top_assert.svh -----
// Assertion macros for the buddy block allocator RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BBA_ASSERT(lbl, prop, msg)
`define BBA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- design/bba_pkg.sv -----
// Shared types, constants and helper functions for the buddy block allocator.
// No dependencies.
package bba_pkg;

  localparam int TOP_ORDER   = 10;
  localparam int POOL_SIZE   = 1024;
  localparam int STACK_DEPTH = 2 * POOL_SIZE - 1;
  localparam int ORD_W       = 4;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int ADDR_W      = 11;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ORDER = 2'd1;
  localparam logic [1:0] ST_NO_BLOCK  = 2'd2;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ORD_W-1:0] order;
    logic [IDX_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted_index;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_A_SCAN, S_A_POP, S_A_TAKE, S_A_SPLIT,
    S_R_CHECK, S_R_SRCH, S_R_CMP, S_R_SHIFT, S_R_SHWR, S_R_PUSH,
    S_C_INIT, S_C_LOOP, S_DONE
  } state_t;

  typedef enum logic [1:0] {RET_ALLOC, RET_FREE, RET_CARVE} ret_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LATCH_ALLOC, OP_LATCH_FREE, OP_LATCH_BAD, OP_LATCH_NONE,
    OP_SET_NO_BLOCK, OP_SCAN_INC, OP_POP, OP_POP_TAKE, OP_SPLIT,
    OP_MATE_INIT, OP_SRCH_RD, OP_SRCH_MISS, OP_SHIFT_INIT, OP_SHIFT_RD,
    OP_SHIFT_WR, OP_MERGE, OP_PUSH, OP_CARVE_INIT, OP_CARVE_REL, OP_CARVE_DEC
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_ck;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic ck_top;
    logic ck_zero;
    logic ck_eq_tgt;
    logic rk_top;
    logic i_zero;
    logic hit;
    logic shift_end;
    logic size_ge;
    logic order_bad;
  } dp_stat_t;

  // First stack slot of order k: orders below take 2*POOL - (2*POOL >> k) slots
  function automatic logic [ADDR_W-1:0] stack_base(input logic [ORD_W-1:0] k);
    return ADDR_W'((2 * POOL_SIZE) - ((2 * POOL_SIZE) >> k));
  endfunction

  function automatic logic [CNT_W-1:0] stack_cap(input logic [ORD_W-1:0] k);
    return CNT_W'(POOL_SIZE >> k);
  endfunction

endpackage

// ----- design/bba_dp.sv -----
// Datapath of the buddy block allocator: free stack memory, counts, work registers.
// Depends on bba_pkg; driven by bba_ctrl through dp_cmd_t.
module bba_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [bba_pkg::CNT_W-1:0] cfg_wdata,
  input  bba_pkg::in_item_t      in_data,
  input  bba_pkg::dp_cmd_t       cmd,
  output bba_pkg::dp_stat_t      stat,
  output bba_pkg::out_item_t     out_data
);

  logic [bba_pkg::IDX_W-1:0] stack_mem [0:bba_pkg::STACK_DEPTH-1];
  logic [bba_pkg::IDX_W-1:0] rdata_r;

  logic [bba_pkg::CNT_W-1:0] cnt_r [0:bba_pkg::TOP_ORDER];
  logic [bba_pkg::CNT_W-1:0] pool_r;
  logic [bba_pkg::ORD_W-1:0] ck_r, tgt_r, rk_r;
  logic [bba_pkg::IDX_W-1:0] ridx_r, gr_r;
  logic [bba_pkg::CNT_W-1:0] p_r, size_r, i_r;
  logic [1:0]                st_r;

  logic [bba_pkg::ORD_W-1:0]  cur_ord;
  logic [bba_pkg::CNT_W-1:0]  cur_cnt;
  logic [bba_pkg::ADDR_W-1:0] cur_base;
  logic [bba_pkg::IDX_W-1:0]  mate;
  logic [bba_pkg::CNT_W-1:0]  span;
  logic [bba_pkg::CNT_W-1:0]  pool_eff;
  logic                       room;
  logic                       mem_we, mem_re;
  logic [bba_pkg::ADDR_W-1:0] waddr, raddr;
  logic [bba_pkg::IDX_W-1:0]  wdata;

  // Order under work and its stack
  assign cur_ord  = cmd.sel_ck ? ck_r : rk_r;
  assign cur_cnt  = cnt_r[cur_ord];
  assign cur_base = bba_pkg::stack_base(cur_ord);
  assign mate     = ridx_r ^ (bba_pkg::IDX_W'(1) << rk_r);
  assign span     = bba_pkg::CNT_W'(1) << ck_r;
  assign room     = cur_cnt < bba_pkg::stack_cap(cur_ord);
  assign pool_eff = (pool_r > bba_pkg::CNT_W'(bba_pkg::POOL_SIZE)) ?
                    bba_pkg::CNT_W'(bba_pkg::POOL_SIZE) : pool_r;

  // Status to the controller
  always_comb begin
    stat.cnt_zero  = (cur_cnt == '0);
    stat.ck_top    = (ck_r == bba_pkg::ORD_W'(bba_pkg::TOP_ORDER));
    stat.ck_zero   = (ck_r == '0);
    stat.ck_eq_tgt = (ck_r == tgt_r);
    stat.rk_top    = (rk_r == bba_pkg::ORD_W'(bba_pkg::TOP_ORDER));
    stat.i_zero    = (i_r == '0);
    stat.hit       = (rdata_r == mate);
    stat.shift_end = ({1'b0, i_r} + 12'd1) >= {1'b0, cnt_r[rk_r]};
    stat.size_ge   = (size_r >= span);
    stat.order_bad = (in_data.order > bba_pkg::ORD_W'(bba_pkg::TOP_ORDER));
  end

  // Memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = cur_base;
    raddr  = cur_base;
    wdata  = ridx_r;
    case (cmd.op)
      bba_pkg::OP_POP: begin
        mem_re = 1'b1;
        raddr  = cur_base + cur_cnt - bba_pkg::ADDR_W'(1);
      end
      bba_pkg::OP_SRCH_RD: begin
        mem_re = 1'b1;
        raddr  = cur_base + i_r - bba_pkg::ADDR_W'(1);
      end
      bba_pkg::OP_SHIFT_RD: begin
        mem_re = 1'b1;
        raddr  = cur_base + i_r + bba_pkg::ADDR_W'(1);
      end
      bba_pkg::OP_SHIFT_WR: begin
        mem_we = 1'b1;
        waddr  = cur_base + i_r;
        wdata  = rdata_r;
      end
      bba_pkg::OP_PUSH: begin
        mem_we = room;
        waddr  = cur_base + cur_cnt;
      end
      default: begin
      end
    endcase
  end

  // Free stack memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= stack_mem[raddr];
    end
  end

  // Counts and pool size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= bba_pkg::TOP_ORDER; k++) cnt_r[k] <= '0;
      pool_r <= bba_pkg::CNT_W'(bba_pkg::POOL_SIZE);
    end else begin
      if (cfg_we) begin
        pool_r <= cfg_wdata;
      end
      case (cmd.op)
        bba_pkg::OP_POP, bba_pkg::OP_MERGE: cnt_r[cur_ord] <= cur_cnt - bba_pkg::CNT_W'(1);
        bba_pkg::OP_PUSH: begin
          if (room) cnt_r[cur_ord] <= cur_cnt + bba_pkg::CNT_W'(1);
        end
        bba_pkg::OP_CARVE_INIT: begin
          for (int k = 0; k <= bba_pkg::TOP_ORDER; k++) cnt_r[k] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      bba_pkg::OP_LATCH_ALLOC: begin
        ck_r  <= in_data.order;
        tgt_r <= in_data.order;
        st_r  <= bba_pkg::ST_OK;
        gr_r  <= '0;
      end
      bba_pkg::OP_LATCH_FREE: begin
        rk_r   <= in_data.order;
        ridx_r <= in_data.block_index & ({bba_pkg::IDX_W{1'b1}} << in_data.order);
        st_r   <= bba_pkg::ST_OK;
        gr_r   <= '0;
      end
      bba_pkg::OP_LATCH_BAD: begin
        st_r <= bba_pkg::ST_BAD_ORDER;
        gr_r <= '0;
      end
      bba_pkg::OP_LATCH_NONE: begin
        st_r <= bba_pkg::ST_OK;
        gr_r <= '0;
      end
      bba_pkg::OP_SET_NO_BLOCK: st_r <= bba_pkg::ST_NO_BLOCK;
      bba_pkg::OP_SCAN_INC:     ck_r <= ck_r + bba_pkg::ORD_W'(1);
      bba_pkg::OP_POP_TAKE: begin
        p_r  <= {1'b0, rdata_r};
        gr_r <= rdata_r;
      end
      bba_pkg::OP_SPLIT: begin
        ck_r   <= ck_r - bba_pkg::ORD_W'(1);
        rk_r   <= ck_r - bba_pkg::ORD_W'(1);
        ridx_r <= p_r[bba_pkg::IDX_W-1:0] |
                  (bba_pkg::IDX_W'(1) << (ck_r - bba_pkg::ORD_W'(1)));
      end
      bba_pkg::OP_MATE_INIT:  i_r <= cnt_r[rk_r];
      bba_pkg::OP_SRCH_MISS:  i_r <= i_r - bba_pkg::CNT_W'(1);
      bba_pkg::OP_SHIFT_INIT: i_r <= i_r - bba_pkg::CNT_W'(1);
      bba_pkg::OP_SHIFT_WR:   i_r <= i_r + bba_pkg::CNT_W'(1);
      bba_pkg::OP_MERGE: begin
        ridx_r <= ridx_r & ~(bba_pkg::IDX_W'(1) << rk_r);
        rk_r   <= rk_r + bba_pkg::ORD_W'(1);
      end
      bba_pkg::OP_CARVE_INIT: begin
        size_r <= pool_eff;
        p_r    <= '0;
        ck_r   <= bba_pkg::ORD_W'(bba_pkg::TOP_ORDER);
        st_r   <= bba_pkg::ST_OK;
        gr_r   <= '0;
      end
      bba_pkg::OP_CARVE_REL: begin
        rk_r   <= ck_r;
        ridx_r <= p_r[bba_pkg::IDX_W-1:0];
        p_r    <= p_r + span;
        size_r <= size_r - span;
      end
      bba_pkg::OP_CARVE_DEC: ck_r <= ck_r - bba_pkg::ORD_W'(1);
      default: begin
      end
    endcase
  end

  assign out_data.status        = st_r;
  assign out_data.granted_index = gr_r;

endmodule

// ----- design/bba_ctrl.sv -----
// Controller state machine of the buddy block allocator.
// Depends on bba_pkg and buddy_block_allocator_top_assert.svh; drives bba_dp.
`include "buddy_block_allocator_top_assert.svh"
module bba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_cmd,
  input  bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              out_strobe
);

  bba_pkg::state_t state_r, state_nxt;
  bba_pkg::ret_t   ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_IDLE;
      ret_r   <= bba_pkg::RET_FREE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      bba_pkg::S_IDLE: begin
        if (start) begin
          case (in_cmd)
            bba_pkg::CMD_ALLOC: begin
              ret_nxt   = bba_pkg::RET_ALLOC;
              state_nxt = stat.order_bad ? bba_pkg::S_DONE : bba_pkg::S_A_SCAN;
            end
            bba_pkg::CMD_FREE: begin
              ret_nxt   = bba_pkg::RET_FREE;
              state_nxt = stat.order_bad ? bba_pkg::S_DONE : bba_pkg::S_R_CHECK;
            end
            bba_pkg::CMD_INIT: begin
              ret_nxt   = bba_pkg::RET_CARVE;
              state_nxt = bba_pkg::S_C_INIT;
            end
            default: state_nxt = bba_pkg::S_DONE;
          endcase
        end
      end
      bba_pkg::S_A_SCAN: begin
        if (!stat.cnt_zero) state_nxt = bba_pkg::S_A_POP;
        else if (stat.ck_top) state_nxt = bba_pkg::S_DONE;
      end
      bba_pkg::S_A_POP:  state_nxt = bba_pkg::S_A_TAKE;
      bba_pkg::S_A_TAKE: state_nxt = bba_pkg::S_A_SPLIT;
      bba_pkg::S_A_SPLIT: begin
        state_nxt = stat.ck_eq_tgt ? bba_pkg::S_DONE : bba_pkg::S_R_CHECK;
      end
      bba_pkg::S_R_CHECK: begin
        state_nxt = stat.rk_top ? bba_pkg::S_R_PUSH : bba_pkg::S_R_SRCH;
      end
      bba_pkg::S_R_SRCH: begin
        state_nxt = stat.i_zero ? bba_pkg::S_R_PUSH : bba_pkg::S_R_CMP;
      end
      bba_pkg::S_R_CMP: begin
        state_nxt = stat.hit ? bba_pkg::S_R_SHIFT : bba_pkg::S_R_SRCH;
      end
      bba_pkg::S_R_SHIFT: begin
        state_nxt = stat.shift_end ? bba_pkg::S_R_CHECK : bba_pkg::S_R_SHWR;
      end
      bba_pkg::S_R_SHWR: state_nxt = bba_pkg::S_R_SHIFT;
      bba_pkg::S_R_PUSH: begin
        case (ret_r)
          bba_pkg::RET_ALLOC: state_nxt = bba_pkg::S_A_SPLIT;
          bba_pkg::RET_CARVE: state_nxt = bba_pkg::S_C_LOOP;
          default:            state_nxt = bba_pkg::S_DONE;
        endcase
      end
      bba_pkg::S_C_INIT: state_nxt = bba_pkg::S_C_LOOP;
      bba_pkg::S_C_LOOP: begin
        if (stat.size_ge) state_nxt = bba_pkg::S_R_CHECK;
        else if (stat.ck_zero) state_nxt = bba_pkg::S_DONE;
      end
      bba_pkg::S_DONE: state_nxt = bba_pkg::S_IDLE;
      default: state_nxt = bba_pkg::S_IDLE;
    endcase
  end

  // Datapath commands and handshake outputs
  always_comb begin
    cmd.op     = bba_pkg::OP_NOP;
    cmd.sel_ck = 1'b0;
    busy       = (state_r != bba_pkg::S_IDLE);
    out_strobe = (state_r == bba_pkg::S_DONE);
    case (state_r)
      bba_pkg::S_IDLE: begin
        if (start) begin
          case (in_cmd)
            bba_pkg::CMD_ALLOC:
              cmd.op = stat.order_bad ? bba_pkg::OP_LATCH_BAD : bba_pkg::OP_LATCH_ALLOC;
            bba_pkg::CMD_FREE:
              cmd.op = stat.order_bad ? bba_pkg::OP_LATCH_BAD : bba_pkg::OP_LATCH_FREE;
            bba_pkg::CMD_INIT: cmd.op = bba_pkg::OP_NOP;
            default:           cmd.op = bba_pkg::OP_LATCH_NONE;
          endcase
        end
      end
      bba_pkg::S_A_SCAN: begin
        cmd.sel_ck = 1'b1;
        if (stat.cnt_zero) begin
          cmd.op = stat.ck_top ? bba_pkg::OP_SET_NO_BLOCK : bba_pkg::OP_SCAN_INC;
        end
      end
      bba_pkg::S_A_POP: begin
        cmd.sel_ck = 1'b1;
        cmd.op     = bba_pkg::OP_POP;
      end
      bba_pkg::S_A_TAKE: cmd.op = bba_pkg::OP_POP_TAKE;
      bba_pkg::S_A_SPLIT: begin
        if (!stat.ck_eq_tgt) cmd.op = bba_pkg::OP_SPLIT;
      end
      bba_pkg::S_R_CHECK: begin
        if (!stat.rk_top) cmd.op = bba_pkg::OP_MATE_INIT;
      end
      bba_pkg::S_R_SRCH: begin
        if (!stat.i_zero) cmd.op = bba_pkg::OP_SRCH_RD;
      end
      bba_pkg::S_R_CMP: begin
        cmd.op = stat.hit ? bba_pkg::OP_SHIFT_INIT : bba_pkg::OP_SRCH_MISS;
      end
      bba_pkg::S_R_SHIFT: begin
        cmd.op = stat.shift_end ? bba_pkg::OP_MERGE : bba_pkg::OP_SHIFT_RD;
      end
      bba_pkg::S_R_SHWR: cmd.op = bba_pkg::OP_SHIFT_WR;
      bba_pkg::S_R_PUSH: cmd.op = bba_pkg::OP_PUSH;
      bba_pkg::S_C_INIT: cmd.op = bba_pkg::OP_CARVE_INIT;
      bba_pkg::S_C_LOOP: begin
        if (stat.size_ge) cmd.op = bba_pkg::OP_CARVE_REL;
        else if (!stat.ck_zero) cmd.op = bba_pkg::OP_CARVE_DEC;
      end
      default: begin
      end
    endcase
  end

  // Result strobe lasts one cycle, then the controller is ready again
  `BBA_ASSERT(a_done_to_idle, (state_r == bba_pkg::S_DONE) |=> (state_r == bba_pkg::S_IDLE), "done not followed by idle")
  // An accepted transaction always leaves idle
  `BBA_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted transaction did not start")
  // Split chain only runs for allocations
  `BBA_ASSERT_NEVER(a_split_mode, (state_r == bba_pkg::S_A_SPLIT) && (ret_r != bba_pkg::RET_ALLOC), "split outside allocation")

endmodule

// ----- design/buddy_block_allocator_top.sv -----
// Top level of the buddy block allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl and bba_dp.
//
//  channel  | ports                          | transfer
//  ---------+--------------------------------+-----------------------------------
//  input    | start, busy, in_data           | start high while busy low
//  result   | out_strobe, out_data           | one-cycle strobe, cannot be held
//  config   | cfg_we, cfg_wdata              | write on cfg_we, no wait
//
// One transaction at a time. An allocation holds busy while it scans orders upward,
// then for pop, take, split check and done, plus the release work of each split.
// A release does, per order, a check, a search of the stack entries from the top
// and a move down of the entries above a hit, then a push and done.
// All of it is bounded by the free stack memory; init walks every
// carved piece the same way. Reset leaves the pool empty until an init command.
// Each result appears on out_strobe for exactly one cycle; the receiver cannot stall.
module buddy_block_allocator_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  bba_pkg::in_item_t          in_data,
  output logic                       out_strobe,
  output bba_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [bba_pkg::CNT_W-1:0]  cfg_wdata
);

  bba_pkg::dp_cmd_t  dp_cmd;
  bba_pkg::dp_stat_t dp_stat;

  bba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_cmd     (in_data.cmd),
    .stat       (dp_stat),
    .cmd        (dp_cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  bba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .out_data  (out_data)
  );

endmodule

// ----- bench/bba_checker.sv -----
// Checker for the buddy block allocator: watches the request, result and config ports.
// Keeps its own copy of the free stacks and predicts every result; depends on bba_pkg.
module bba_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  bba_pkg::in_item_t          in_data,
  input  logic                       out_strobe,
  input  bba_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [bba_pkg::CNT_W-1:0]  cfg_wdata,
  output int                         fail_count,
  output int                         results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int NUM_ORDERS = TOP_ORDER + 1;

  // Shadow allocator state
  logic [IDX_W-1:0] shadow_stk [0:2*POOL_SIZE-1];
  int               shadow_cnt [NUM_ORDERS];
  int               order_base [NUM_ORDERS];
  int               order_cap  [NUM_ORDERS];
  int               pool_cfg;

  out_item_t        owed_q [$];

  // Remove the topmost copy of blk from the order-k stack
  function automatic bit unlink_block(int blk, int k);
    int n;
    n = shadow_cnt[k];
    for (int i = n; i > 0; i--) begin
      if (shadow_stk[order_base[k] + i - 1] == IDX_W'(blk)) begin
        for (int j = i - 1; j + 1 < n; j++)
          shadow_stk[order_base[k] + j] = shadow_stk[order_base[k] + j + 1];
        shadow_cnt[k] = n - 1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Free with buddy coalescing; a push onto a full stack is lost
  function automatic void coalesce_free(int blk, int k);
    blk = blk & ~((1 << k) - 1);
    while (k < TOP_ORDER) begin
      if (!unlink_block(blk ^ (1 << k), k)) break;
      blk = blk & ~(1 << k);
      k++;
    end
    if (shadow_cnt[k] < order_cap[k]) begin
      shadow_stk[order_base[k] + shadow_cnt[k]] = IDX_W'(blk);
      shadow_cnt[k]++;
    end
  endfunction

  // Pop from the first nonempty order at or above k, splitting down
  function automatic bit split_alloc(int k, output int blk);
    int j;
    j = k;
    blk = 0;
    while (j <= TOP_ORDER && shadow_cnt[j] == 0) j++;
    if (j > TOP_ORDER) return 1'b0;
    shadow_cnt[j]--;
    blk = shadow_stk[order_base[j] + shadow_cnt[j]];
    while (j > k) begin
      j--;
      coalesce_free(blk + (1 << j), j);
    end
    return 1'b1;
  endfunction

  function automatic void carve_pool();
    int size;
    int p;
    size = (pool_cfg > POOL_SIZE) ? POOL_SIZE : pool_cfg;
    p = 0;
    for (int k = 0; k < NUM_ORDERS; k++) shadow_cnt[k] = 0;
    for (int k = TOP_ORDER; k >= 0; k--) begin
      while (size >= (1 << k)) begin
        coalesce_free(p, k);
        p += 1 << k;
        size -= 1 << k;
      end
    end
  endfunction

  function automatic out_item_t predict_result(in_item_t req);
    out_item_t res;
    int blk;
    res = '0;
    res.status = ST_OK;
    case (req.cmd)
      CMD_ALLOC: begin
        if (req.order > TOP_ORDER) res.status = ST_BAD_ORDER;
        else if (split_alloc(int'(req.order), blk)) res.granted_index = IDX_W'(blk);
        else res.status = ST_NO_BLOCK;
      end
      CMD_FREE: begin
        if (req.order > TOP_ORDER) res.status = ST_BAD_ORDER;
        else coalesce_free(int'(req.block_index), int'(req.order));
      end
      CMD_INIT: carve_pool();
      default: ;
    endcase
    return res;
  endfunction

  // Sample all channels at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    int        b;
    if (!rst_n) begin
      b = 0;
      for (int k = 0; k < NUM_ORDERS; k++) begin
        order_base[k] = b;
        order_cap[k]  = POOL_SIZE >> k;
        shadow_cnt[k] = 0;
        b += order_cap[k];
      end
      pool_cfg = 1024;
      owed_q.delete();
    end else begin
      if (cfg_we) pool_cfg = int'(cfg_wdata);
      if (out_strobe) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result transaction: status %0d index %0d",
                 out_data.status, out_data.granted_index);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.granted_index !== want.granted_index) begin
            $error("granted_index: expected %0d, got %0d",
                   want.granted_index, out_data.granted_index);
            fail_count++;
          end
        end
      end
      if (start && !busy) owed_q.push_back(predict_result(in_data));
    end
    results_owed = owed_q.size();
  end

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

endmodule

// ----- bench/tb_buddy_block_allocator_top.sv -----
// Testbench top for buddy_block_allocator_top: clock, reset, stimulus and verdict.
// Depends on bba_pkg, the allocator RTL and bba_checker.
module tb_buddy_block_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int PER_PHASE   = 89;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_item_t          in_data = '0;
  logic              out_strobe;
  out_item_t         out_data;
  logic              cfg_we = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata = '0;
  int                fail_count;
  int                results_owed;
  int                cycles = 0;

  typedef struct {
    logic [IDX_W-1:0] blk;
    logic [ORD_W-1:0] ord;
  } held_t;

  held_t    held_blocks [$];
  in_item_t issued_q [$];

  always #5 clk = ~clk;

  buddy_block_allocator_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  bba_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Track granted blocks so later frees hit real allocations
  always @(posedge clk) begin
    in_item_t req;
    if (out_strobe && issued_q.size() > 0) begin
      req = issued_q.pop_front();
      if (req.cmd == CMD_INIT) held_blocks.delete();
      else if (req.cmd == CMD_ALLOC && out_data.status == ST_OK)
        held_blocks.push_back('{out_data.granted_index, req.order});
    end
  end

  // One transaction; called and returns at a falling edge
  task automatic send_req(logic [1:0] cmd, int ord, int blk);
    bit took;
    int gap;
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_data.cmd = cmd;
    in_data.order = ORD_W'(ord);
    in_data.block_index = IDX_W'(blk);
    forever begin
      took = !busy;
      @(posedge clk);
      if (took) break;
      @(negedge clk);
    end
    issued_q.push_back(in_data);
    @(negedge clk);
  endtask

  // Hold off until every owed result is back
  task automatic drain();
    start = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_pool(int blocks);
    cfg_we = 1'b1;
    cfg_wdata = CNT_W'(blocks);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly real alloc/free traffic, with stray frees, bad orders, re-inits and unused commands
  task automatic random_req();
    int roll;
    int pick;
    int ord;
    held_t h;
    roll = $urandom_range(0, 99);
    if (roll < 46) begin
      pick = $urandom_range(0, 99);
      ord = (pick < 5) ? $urandom_range(11, 15) :
            (pick < 20) ? $urandom_range(5, 10) : $urandom_range(0, 4);
      send_req(CMD_ALLOC, ord, $urandom_range(0, 1023));
    end else if (roll < 95) begin
      if (held_blocks.size() > 0 && $urandom_range(0, 9) < 8) begin
        pick = $urandom_range(0, held_blocks.size() - 1);
        h = held_blocks[pick];
        // occasionally leave it held, giving a double free later
        if ($urandom_range(0, 19) != 0) held_blocks.delete(pick);
        // occasionally misalign the index
        if ($urandom_range(0, 9) == 0) h.blk = h.blk | IDX_W'($urandom_range(0, 1023) & ((1 << h.ord) - 1));
        send_req(CMD_FREE, h.ord, h.blk);
      end else begin
        send_req(CMD_FREE, $urandom_range(0, 15), $urandom_range(0, 1023));
      end
    end else if (roll < 97) begin
      send_req(CMD_INIT, $urandom_range(0, 15), $urandom_range(0, 1023));
    end else begin
      send_req(CMD_UNUSED, $urandom_range(0, 15), $urandom_range(0, 1023));
    end
  endtask

  initial begin
    int pool_sizes [7];
    pool_sizes = '{1024, 0, 2047, 1, 1023, 513, 0};
    pool_sizes[6] = $urandom_range(2, 1023);

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    write_pool(1024);

    // Directed: empty pool, bad orders, unused command, merges, odd frees
    send_req(CMD_ALLOC, 0, 0);
    send_req(CMD_ALLOC, 11, 0);
    send_req(CMD_FREE, 15, 1023);
    send_req(CMD_UNUSED, 15, 1023);
    send_req(CMD_INIT, 0, 0);
    send_req(CMD_ALLOC, 10, 0);
    send_req(CMD_ALLOC, 0, 0);
    send_req(CMD_FREE, 10, 0);
    send_req(CMD_ALLOC, 0, 0);
    send_req(CMD_ALLOC, 3, 0);
    send_req(CMD_FREE, 2, 1023);
    send_req(CMD_FREE, 0, 0);
    send_req(CMD_FREE, 3, 8);
    send_req(CMD_ALLOC, 10, 0);
    send_req(CMD_FREE, 0, 1023);
    send_req(CMD_FREE, 0, 1023);
    send_req(CMD_ALLOC, 15, 0);
    send_req(CMD_INIT, 0, 0);
    send_req(CMD_ALLOC, 10, 0);
    send_req(CMD_ALLOC, 9, 0);
    drain();

    // Random phases, one pool setting each
    foreach (pool_sizes[p]) begin
      write_pool(pool_sizes[p]);
      send_req(CMD_INIT, 0, 0);
      repeat (PER_PHASE) random_req();
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
